// ===== src/cfct_pkg.sv =====
// ----------------------------------------------------------------------------
// cfct_pkg
// shared types and constants of the can frame cache table
// ----------------------------------------------------------------------------
`default_nettype none

package cfct_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CUR_W       = CNT_W + 8;
    localparam int MAX_BYTES   = 8;
    localparam int ID_W        = 29;
    localparam int DATA_W      = 64;

    typedef enum logic [1:0] {
        FN_UPDATE = 2'd0,
        FN_NEXT   = 2'd1,
        FN_LOOKUP = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_CAPTURE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic              ext;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   frame_id;
        logic [DATA_W-1:0] frame_payload;
        logic [7:0]        next_cursor;
    } t_result;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] used;
    } t_status;

endpackage

`default_nettype wire

// ===== src/cfct_table_ram.sv =====
// ----------------------------------------------------------------------------
// cfct_table_ram
// entry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module cfct_table_ram
    import cfct_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_entry           i_wdata,
    input  wire logic             i_re,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_entry                o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/cfct_seq.sv =====
// ----------------------------------------------------------------------------
// cfct_seq
// sequencer: scans the table one entry a cycle through a shared key compare
// ----------------------------------------------------------------------------
`default_nettype none

module cfct_seq
    import cfct_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [1:0]        i_func,
    input  wire logic [ID_W-1:0]   i_identifier,
    input  wire logic              i_is_extended,
    input  wire logic [7:0]        i_length_code,
    input  wire logic [DATA_W-1:0] i_payload,
    input  wire logic [7:0]        i_cursor,
    input  wire logic              i_out_free,
    output t_status                o_status,
    output logic                   o_res_valid,
    output t_result                o_result
);

    t_state              r_state, n_state;
    t_func               r_func;
    logic [ID_W-1:0]     r_id;
    logic                r_ext;
    logic [DATA_W-1:0]   r_data;
    logic [7:0]          r_cursor;
    logic [IDX_W-1:0]    r_start;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_idx;
    logic                r_pend;
    logic [IDX_W-1:0]    r_pidx;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [ID_W-1:0]     r_res_id;
    logic [DATA_W-1:0]   r_res_data;

    t_entry              w_rd;
    t_entry              w_wdata;
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic                w_re;
    logic [IDX_W-1:0]    w_raddr;
    logic                w_match;
    logic                w_more;
    logic                w_room;
    logic                w_alloc;
    logic [DATA_W-1:0]   w_clip;
    logic [IDX_W-1:0]    w_start;
    logic [CUR_W-1:0]    w_cur_ext;
    logic [CUR_W-1:0]    w_used_ext;
    logic [CUR_W-1:0]    w_inc;
    logic [CUR_W-1:0]    w_ncur;

    cfct_table_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // byte b survives when the length code exceeds b
    always_comb begin
        for (int b = 0; b < MAX_BYTES; b++) begin
            w_clip[b*8 +: 8] = (i_length_code > 8'(b)) ? i_payload[b*8 +: 8] : 8'd0;
        end
    end

    assign w_cur_ext  = {{CNT_W{1'b0}}, i_cursor};
    assign w_used_ext = {8'd0, r_used};
    assign w_start    = (w_cur_ext >= w_used_ext) ? '0 : i_cursor[IDX_W-1:0];
    assign w_inc      = {{(CUR_W-IDX_W){1'b0}}, r_start} + CUR_W'(1);
    assign w_ncur     = (w_inc == w_used_ext) ? '0 : w_inc;

    // shared key compare on the entry read in the previous cycle
    assign w_match = r_pend && (w_rd.id == r_id) && ((r_func == FN_LOOKUP) || (w_rd.ext == r_ext));
    assign w_more  = (r_idx < r_used);
    assign w_room  = (r_used < CNT_W'(TABLE_DEPTH));
    assign w_alloc = (r_func == FN_UPDATE) && !r_hit && w_room;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    case (t_func'(i_func))
                        FN_UPDATE, FN_LOOKUP: n_state = ST_SCAN;
                        FN_NEXT:              n_state = (r_used == '0) ? ST_FINISH : ST_READ;
                        default:              n_state = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN: begin
                if (w_match || !w_more) begin
                    n_state = ST_FINISH;
                end
            end
            ST_READ:    n_state = ST_CAPTURE;
            ST_CAPTURE: n_state = ST_FINISH;
            ST_FINISH: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_re        = 1'b0;
        w_raddr     = r_idx[IDX_W-1:0];
        w_we        = 1'b0;
        w_waddr     = r_hit ? r_hit_idx : r_used[IDX_W-1:0];
        w_wdata     = '{ext: r_ext, id: r_id, data: r_data};
        o_res_valid = 1'b0;
        case (r_state)
            ST_SCAN: begin
                w_re = !w_match && w_more;
            end
            ST_READ: begin
                w_re    = 1'b1;
                w_raddr = r_start;
            end
            ST_FINISH: begin
                o_res_valid = i_out_free;
                w_we        = i_out_free && (r_func == FN_UPDATE) && (r_hit || w_room);
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_result.found         = (r_func == FN_UPDATE) ? (r_hit || w_room) : r_hit;
        o_result.frame_id      = r_res_id;
        o_result.frame_payload = r_res_data;
        o_result.next_cursor   = ((r_func == FN_NEXT) && r_hit) ? w_ncur[7:0] : r_cursor;
    end

    assign o_status = '{busy: (r_state != ST_IDLE), used: r_used};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_FINISH) && i_out_free && w_alloc) begin
                r_used <= r_used + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    r_func     <= t_func'(i_func);
                    r_id       <= i_identifier;
                    r_ext      <= i_is_extended;
                    r_data     <= w_clip;
                    r_cursor   <= i_cursor;
                    r_start    <= w_start;
                    r_idx      <= '0;
                    r_pend     <= 1'b0;
                    r_hit      <= 1'b0;
                    r_res_id   <= '0;
                    r_res_data <= '0;
                end
            end
            ST_SCAN: begin
                if (w_match) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_pidx;
                    r_pend    <= 1'b0;
                    if (r_func == FN_LOOKUP) begin
                        r_res_id   <= w_rd.id;
                        r_res_data <= w_rd.data;
                    end
                end else if (w_more) begin
                    r_pend <= 1'b1;
                    r_pidx <= r_idx[IDX_W-1:0];
                    r_idx  <= r_idx + CNT_W'(1);
                end else begin
                    r_pend <= 1'b0;
                end
            end
            ST_CAPTURE: begin
                r_hit      <= 1'b1;
                r_res_id   <= w_rd.id;
                r_res_data <= w_rd.data;
            end
            default: begin
                r_pend <= r_pend;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/can_frame_cache_table.sv =====
// ----------------------------------------------------------------------------
// can_frame_cache_table
// cache of received can frames keyed by identifier and format, with
// update, round-robin read and identifier lookup
// ----------------------------------------------------------------------------
// scan: update and lookup compare one table entry per cycle through the
//   single read port until a match or the end of the fill; round-robin
//   read passes through the read, capture and finish states
// throughput: one item at a time, the next input transfer is taken once the
//   previous result sits in the output register
// reset: synchronous active low, empties the table (fill count cleared),
//   entry storage itself is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module can_frame_cache_table
    import cfct_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_func,
    input  wire logic [ID_W-1:0]   i_identifier,
    input  wire logic              i_is_extended,
    input  wire logic [7:0]        i_length_code,
    input  wire logic [DATA_W-1:0] i_payload,
    input  wire logic [7:0]        i_cursor,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_found,
    output logic [ID_W-1:0]        o_frame_id,
    output logic [DATA_W-1:0]      o_frame_payload,
    output logic [7:0]             o_next_cursor
);

    t_status           s_status;
    t_result           s_result;
    logic              s_res_valid;
    logic              s_accept;
    logic              s_out_free;

    logic              r_out_valid;
    t_result           r_out;

    // input transfer only while the sequencer sits idle
    assign o_in_stall = s_status.busy;
    assign s_accept   = i_in_valid && !s_status.busy;

    // output register is free when empty or being drained this cycle
    assign s_out_free = !r_out_valid || !i_out_stall;

    cfct_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_accept),
        .i_func        (i_func),
        .i_identifier  (i_identifier),
        .i_is_extended (i_is_extended),
        .i_length_code (i_length_code),
        .i_payload     (i_payload),
        .i_cursor      (i_cursor),
        .i_out_free    (s_out_free),
        .o_status      (s_status),
        .o_res_valid   (s_res_valid),
        .o_result      (s_result)
    );

    // result register, control bit reset, payload loaded on a new result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_res_valid) begin
            r_out <= s_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_out.found;
    assign o_frame_id      = r_out.frame_id;
    assign o_frame_payload = r_out.frame_payload;
    assign o_next_cursor   = r_out.next_cursor;

    // an accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> o_in_stall)
        else $error("input taken while previous item in flight");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_valid |-> (!r_out_valid || !i_out_stall))
        else $error("result register overwritten");

    // fill count stays within the table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_status.used <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // a miss carries no frame
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> ((o_frame_id == '0) && (o_frame_payload == '0)))
        else $error("frame fields nonzero on a miss");

endmodule

`default_nettype wire
